// File: design/pcl_pkg.sv
`default_nettype none

package pcl_pkg;

  localparam logic [2:0] OP_APPEND     = 3'd0;
  localparam logic [2:0] OP_PREPEND    = 3'd1;
  localparam logic [2:0] OP_INSERT_AT  = 3'd2;
  localparam logic [2:0] OP_DEL_FRONT  = 3'd3;
  localparam logic [2:0] OP_DEL_REAR   = 3'd4;
  localparam logic [2:0] OP_DEL_AT     = 3'd5;
  localparam logic [2:0] OP_SHOW       = 3'd6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] value;
    logic [7:0]         position;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] value_res;
    logic [5:0]         length;
    logic               last;
  } rsp_t;

endpackage

`default_nettype wire

// File: design/positional_circular_list.sv
// insert/delete walking k links from the tail: S_WALK follows them, then S_INS_PRED
// or S_DEL_FIN, then S_RESP; empty-list insert, full insert, empty delete/show: S_RESP
// show of n items: S_SHOW_FIRST, then S_SHOW, one beat per cycle unless rsp_stall holds
// next command accepted the cycle after its last beat is loaded; the link walk, one
// link read per cycle, sets how long a command takes
// rst (synchronous) empties the list; memories are not cleared
`default_nettype none

module positional_circular_list #(
  parameter int CAPACITY    = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_stall,
  input  wire pcl_pkg::cmd_t cmd,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output pcl_pkg::rsp_t      rsp
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 8) ? CW + 1 : 9;

  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_WALK       = 3'd1;
  localparam logic [2:0] S_INS_PRED   = 3'd2;
  localparam logic [2:0] S_DEL_FIN    = 3'd3;
  localparam logic [2:0] S_SHOW_FIRST = 3'd4;
  localparam logic [2:0] S_SHOW       = 3'd5;
  localparam logic [2:0] S_RESP       = 3'd6;

  logic [2:0]          state;
  logic [CAPACITY-1:0] used;
  logic [IW-1:0]       tail;
  logic [CW-1:0]       count;

  logic [IW-1:0]       p;
  logic [IW-1:0]       slot;
  logic [IW-1:0]       victim;
  logic [CW-1:0]       remaining;
  logic [CW-1:0]       idx;
  logic                ins_op;
  logic                tail_upd;
  logic [1:0]          pend_status;
  logic signed [31:0]  pend_value;

  // memories
  logic signed [VALUE_WIDTH-1:0] item_mem [CAPACITY];
  logic [IW-1:0]                 link_mem [CAPACITY];
  logic signed [VALUE_WIDTH-1:0] item_q;
  logic [IW-1:0]                 link_q;

  logic                          link_we, link_re, item_we, item_re;
  logic [IW-1:0]                 link_waddr, link_wdata, link_raddr;
  logic [IW-1:0]                 item_waddr, item_raddr;
  logic signed [VALUE_WIDTH-1:0] item_wdata;

  logic                          cmd_accept, rsp_free, rsp_load;
  logic                          is_ins, is_del, is_show, full, show_last;
  logic [IW-1:0]                 free_slot;
  logic [PW-1:0]                 pos_w, n_w;
  logic [CW-1:0]                 k_ins, k_del;
  logic signed [VALUE_WIDTH-1:0] cmd_value_w;

  pcl_free_slot #(
    .CAPACITY(CAPACITY),
    .IW      (IW)
  ) u_free_slot (
    .used(used),
    .slot(free_slot)
  );

  assign cmd_stall   = (state != S_IDLE);
  assign cmd_accept  = cmd_valid && !cmd_stall;
  assign rsp_free    = !rsp_valid || !rsp_stall;
  assign rsp_load    = ((state == S_SHOW) || (state == S_RESP)) && rsp_free;
  assign cmd_value_w = VALUE_WIDTH'(cmd.value);
  assign full        = (count == CW'(CAPACITY));
  assign show_last   = (CW'(idx + 1'b1) == count);

  assign is_ins  = (cmd.op == pcl_pkg::OP_APPEND) || (cmd.op == pcl_pkg::OP_PREPEND) ||
                   (cmd.op == pcl_pkg::OP_INSERT_AT);
  assign is_del  = (cmd.op == pcl_pkg::OP_DEL_FRONT) || (cmd.op == pcl_pkg::OP_DEL_REAR) ||
                   (cmd.op == pcl_pkg::OP_DEL_AT);
  assign is_show = (cmd.op == pcl_pkg::OP_SHOW);

  assign pos_w = PW'(cmd.position);
  assign n_w   = PW'(count);

  // number of links to follow from the tail to reach the predecessor
  always_comb begin
    priority if (cmd.op == pcl_pkg::OP_APPEND) begin
      k_ins = count;
    end else if (cmd.op == pcl_pkg::OP_PREPEND || pos_w <= PW'(1)) begin
      k_ins = '0;
    end else if (pos_w - PW'(1) > n_w) begin
      k_ins = count;
    end else begin
      k_ins = CW'(pos_w - PW'(1));
    end
  end

  always_comb begin
    priority if (count == '0 || cmd.op == pcl_pkg::OP_DEL_FRONT) begin
      k_del = '0;
    end else if (cmd.op == pcl_pkg::OP_DEL_REAR) begin
      k_del = CW'(count - 1'b1);
    end else if (pos_w <= PW'(1)) begin
      k_del = '0;
    end else if (pos_w > n_w) begin
      k_del = CW'(count - 1'b1);
    end else begin
      k_del = CW'(pos_w - PW'(1));
    end
  end

  // memory port control
  always_comb begin
    link_we    = 1'b0;
    link_waddr = slot;
    link_wdata = slot;
    link_re    = 1'b0;
    link_raddr = link_q;
    item_we    = 1'b0;
    item_waddr = free_slot;
    item_wdata = cmd_value_w;
    item_re    = 1'b0;
    item_raddr = link_q;
    unique case (state)
      S_IDLE: begin
        if (cmd_accept) begin
          if (is_ins && !full) begin
            item_we = 1'b1;
            if (count == '0) begin
              link_we    = 1'b1;
              link_waddr = free_slot;
              link_wdata = free_slot;
            end else begin
              link_re    = 1'b1;
              link_raddr = tail;
            end
          end else if ((is_del || is_show) && count != '0) begin
            link_re    = 1'b1;
            link_raddr = tail;
          end
        end
      end
      S_WALK: begin
        if (remaining != '0) begin
          link_re = 1'b1;
        end else if (ins_op) begin
          link_we    = 1'b1;
          link_waddr = slot;
          link_wdata = link_q;
        end else begin
          link_re = 1'b1;
          item_re = 1'b1;
        end
      end
      S_INS_PRED: begin
        link_we    = 1'b1;
        link_waddr = p;
        link_wdata = slot;
      end
      S_DEL_FIN: begin
        if (count > CW'(1)) begin
          link_we    = 1'b1;
          link_waddr = p;
          link_wdata = link_q;
        end
      end
      S_SHOW_FIRST: begin
        link_re = 1'b1;
        item_re = 1'b1;
      end
      S_SHOW: begin
        if (rsp_free && !show_last) begin
          link_re = 1'b1;
          item_re = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (link_re) begin
      link_q <= link_mem[link_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (item_we) begin
      item_mem[item_waddr] <= item_wdata;
    end
    if (item_re) begin
      item_q <= item_mem[item_raddr];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      used      <= '0;
      tail      <= '0;
      count     <= '0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_accept) begin
            pend_status <= (is_ins && full)             ? pcl_pkg::ST_FULL  :
                           (!is_ins && count == '0)     ? pcl_pkg::ST_EMPTY :
                                                          pcl_pkg::ST_OK;
            pend_value  <= '0;
            p           <= tail;
            slot        <= free_slot;
            idx         <= '0;
            ins_op      <= is_ins;
            tail_upd    <= (k_ins == count);
            if (is_ins) begin
              if (full) begin
                state <= S_RESP;
              end else if (count == '0) begin
                used[free_slot] <= 1'b1;
                tail            <= free_slot;
                count           <= CW'(count + 1'b1);
                state           <= S_RESP;
              end else begin
                remaining <= k_ins;
                state     <= S_WALK;
              end
            end else if (is_del || is_show) begin
              if (count == '0) begin
                state <= S_RESP;
              end else if (is_del) begin
                remaining <= k_del;
                state     <= S_WALK;
              end else begin
                state <= S_SHOW_FIRST;
              end
            end
          end
        end
        S_WALK: begin
          if (remaining != '0) begin
            p         <= link_q;
            remaining <= CW'(remaining - 1'b1);
          end else if (ins_op) begin
            state <= S_INS_PRED;
          end else begin
            victim <= link_q;
            state  <= S_DEL_FIN;
          end
        end
        S_INS_PRED: begin
          used[slot] <= 1'b1;
          count      <= CW'(count + 1'b1);
          if (tail_upd) begin
            tail <= slot;
          end
          state <= S_RESP;
        end
        S_DEL_FIN: begin
          if (count > CW'(1) && victim == tail) begin
            tail <= p;
          end
          used[victim] <= 1'b0;
          count        <= CW'(count - 1'b1);
          pend_value   <= 32'(item_q);
          state        <= S_RESP;
        end
        S_SHOW_FIRST: begin
          state <= S_SHOW;
        end
        S_SHOW: begin
          if (rsp_free) begin
            rsp.status    <= pcl_pkg::ST_OK;
            rsp.value_res <= 32'(item_q);
            rsp.length    <= 6'(count);
            rsp.last      <= show_last;
            idx           <= CW'(idx + 1'b1);
            if (show_last) begin
              state <= S_IDLE;
            end
          end
        end
        S_RESP: begin
          if (rsp_free) begin
            rsp.status    <= pend_status;
            rsp.value_res <= pend_value;
            rsp.length    <= 6'(count);
            rsp.last      <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("item count above capacity");

  a_used_matches_count: assert property (@(posedge clk) disable iff (rst)
    $countones(used) == int'(count))
    else $error("slot mask out of step with item count");

  a_empty_delete: assert property (@(posedge clk) disable iff (rst)
    cmd_accept && count == '0 &&
    (cmd.op == pcl_pkg::OP_DEL_FRONT || cmd.op == pcl_pkg::OP_DEL_REAR ||
     cmd.op == pcl_pkg::OP_DEL_AT)
    |=> state == S_RESP && pend_status == pcl_pkg::ST_EMPTY)
    else $error("delete on empty list not flagged");

  a_show_index: assert property (@(posedge clk) disable iff (rst)
    state == S_SHOW |-> idx < count)
    else $error("show walked past the rear");

endmodule

`default_nettype wire

// File: design/pcl_free_slot.sv
`default_nettype none

module pcl_free_slot #(
  parameter int CAPACITY = 32,
  parameter int IW       = 5
) (
  input  wire logic [CAPACITY-1:0] used,
  output logic      [IW-1:0]       slot
);

  // lowest free slot, scanned from the top so the lowest one wins
  always_comb begin
    slot = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!used[i]) begin
        slot = IW'(i);
      end
    end
  end

endmodule

`default_nettype wire

// File: tb/positional_circular_list_chk.sv
`timescale 1ns / 1ps

module positional_circular_list_chk #(
  parameter int CAPACITY = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  input  wire logic          cmd_stall,
  input  wire pcl_pkg::cmd_t cmd,
  input  wire logic          rsp_valid,
  input  wire logic          rsp_stall,
  input  wire pcl_pkg::rsp_t rsp,
  output int                 failures,
  output int                 pending,
  output int                 beats,
  output int                 peak_length
);

  // list contents front to rear, and the beats they should produce
  logic signed [31:0] held_list[$];
  pcl_pkg::rsp_t      expected_beats[$];

  task automatic apply_command(input pcl_pkg::cmd_t c);
    int            n;
    int            k;
    int            p;
    pcl_pkg::rsp_t r;
    n = held_list.size();
    p = int'(c.position);
    r = '0;
    r.last = 1'b1;
    case (c.op)
      pcl_pkg::OP_APPEND, pcl_pkg::OP_PREPEND, pcl_pkg::OP_INSERT_AT: begin
        if (c.op == pcl_pkg::OP_APPEND) k = n;
        else if (c.op == pcl_pkg::OP_PREPEND || p <= 1) k = 0;
        else if (p - 1 > n) k = n;
        else k = p - 1;
        if (n >= CAPACITY) begin
          r.status = pcl_pkg::ST_FULL;
        end else begin
          held_list.insert(k, c.value);
          r.status = pcl_pkg::ST_OK;
        end
        r.length = 6'(held_list.size());
        expected_beats.push_back(r);
      end
      pcl_pkg::OP_DEL_FRONT, pcl_pkg::OP_DEL_REAR, pcl_pkg::OP_DEL_AT: begin
        if (n == 0) begin
          r.status = pcl_pkg::ST_EMPTY;
        end else begin
          if (c.op == pcl_pkg::OP_DEL_FRONT || (c.op == pcl_pkg::OP_DEL_AT && p <= 1)) k = 0;
          else if (c.op == pcl_pkg::OP_DEL_REAR || p > n) k = n - 1;
          else k = p - 1;
          r.status    = pcl_pkg::ST_OK;
          r.value_res = held_list[k];
          held_list.delete(k);
        end
        r.length = 6'(held_list.size());
        expected_beats.push_back(r);
      end
      pcl_pkg::OP_SHOW: begin
        if (n == 0) begin
          r.status = pcl_pkg::ST_EMPTY;
          expected_beats.push_back(r);
        end else begin
          for (k = 0; k < n; k++) begin
            r.status    = pcl_pkg::ST_OK;
            r.value_res = held_list[k];
            r.length    = 6'(n);
            r.last      = (k == n - 1);
            expected_beats.push_back(r);
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    pcl_pkg::rsp_t want;
    bit            bad;
    string         what;
    bad = 1'b0;
    if (rst) begin
      held_list.delete();
      expected_beats.delete();
      failures    <= 0;
      pending     <= 0;
      beats       <= 0;
      peak_length <= 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        beats <= beats + 1;
        if (expected_beats.size() == 0) begin
          bad  = 1'b1;
          what = $sformatf("unexpected beat: status %0d value %0d length %0d last %0d",
                           rsp.status, rsp.value_res, rsp.length, rsp.last);
        end else begin
          want = expected_beats.pop_front();
          if (rsp.status !== want.status || rsp.value_res !== want.value_res ||
              rsp.length !== want.length || rsp.last !== want.last) begin
            bad  = 1'b1;
            what = $sformatf({"mismatch: expected status %0d value %0d length %0d last %0d,",
                              " got status %0d value %0d length %0d last %0d"},
                             want.status, want.value_res, want.length, want.last,
                             rsp.status, rsp.value_res, rsp.length, rsp.last);
          end
        end
      end
      if (bad) begin
        if (failures < 10) $display("%s", what);
        failures <= failures + 1;
      end
      if (cmd_valid && !cmd_stall) apply_command(cmd);
      pending <= expected_beats.size();
      if (held_list.size() > peak_length) peak_length <= held_list.size();
    end
  end

endmodule

// File: tb/positional_circular_list_tb.sv
`timescale 1ns / 1ps

module positional_circular_list_tb;

  localparam logic [2:0] OP_UNUSED   = 3'd7;
  localparam int         CAPACITY    = 32;
  localparam int         CYCLE_LIMIT = 250000;
  localparam int         HOLD_CYCLES = 400;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          cmd_valid = 1'b0;
  logic          cmd_stall;
  pcl_pkg::cmd_t cmd       = '0;
  logic          rsp_valid;
  logic          rsp_stall = 1'b0;
  pcl_pkg::rsp_t rsp;

  bit send_gaps  = 1'b1;
  bit stall_gaps = 1'b1;
  bit hold_req   = 1'b0;
  int sent       = 0;
  int failures;
  int pending;
  int beats;
  int peak_length;

  positional_circular_list #(
    .CAPACITY   (CAPACITY),
    .VALUE_WIDTH(32)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd      (cmd),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  positional_circular_list_chk #(
    .CAPACITY(CAPACITY)
  ) i_chk (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .failures   (failures),
    .pending    (pending),
    .beats      (beats),
    .peak_length(peak_length)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin : watchdog
    int cycles;
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin : rsp_side
    int gap;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (stall_gaps && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 9);
        rsp_stall <= 1'b1;
        repeat (gap) @(posedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  task automatic send(input pcl_pkg::cmd_t c);
    int gap;
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    do @(posedge clk); while (cmd_stall);
    sent++;
  endtask

  task automatic send_op(input logic [2:0] op, input logic signed [31:0] value,
                         input logic [7:0] position);
    pcl_pkg::cmd_t c;
    c.op       = op;
    c.value    = value;
    c.position = position;
    send(c);
  endtask

  // grow_pct steers the share of inserts among inserts and deletes
  function automatic pcl_pkg::cmd_t random_cmd(input int grow_pct);
    pcl_pkg::cmd_t c;
    int            roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      c.op = pcl_pkg::OP_SHOW;
    end else if ($urandom_range(0, 99) < grow_pct) begin
      case ($urandom_range(0, 2))
        0:       c.op = pcl_pkg::OP_APPEND;
        1:       c.op = pcl_pkg::OP_PREPEND;
        default: c.op = pcl_pkg::OP_INSERT_AT;
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0:       c.op = pcl_pkg::OP_DEL_FRONT;
        1:       c.op = pcl_pkg::OP_DEL_REAR;
        default: c.op = pcl_pkg::OP_DEL_AT;
      endcase
    end
    if ($urandom_range(0, 39) == 0) c.op = OP_UNUSED;
    case ($urandom_range(0, 11))
      0:       c.value = 32'sh7FFF_FFFF;
      1:       c.value = 32'sh8000_0000;
      2:       c.value = '0;
      3:       c.value = '1;
      default: c.value = $urandom;
    endcase
    if ($urandom_range(0, 3) == 0) c.position = 8'($urandom_range(0, 255));
    else c.position = 8'($urandom_range(0, CAPACITY + 2));
    return c;
  endfunction

  initial begin : stimulus
    int i;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // empty list
    send_op(pcl_pkg::OP_SHOW, 32'sd0, 8'd0);
    send_op(pcl_pkg::OP_DEL_FRONT, 32'sd0, 8'd0);
    send_op(pcl_pkg::OP_DEL_REAR, 32'sd0, 8'd0);
    send_op(pcl_pkg::OP_DEL_AT, 32'sd0, 8'd0);
    // every insert flavor, front and past-end positions
    send_op(pcl_pkg::OP_APPEND, 32'sh7FFF_FFFF, 8'd0);
    send_op(pcl_pkg::OP_PREPEND, 32'sh8000_0000, 8'd0);
    send_op(pcl_pkg::OP_INSERT_AT, 32'sd0, 8'd0);
    send_op(pcl_pkg::OP_INSERT_AT, -32'sd1, 8'd1);
    send_op(pcl_pkg::OP_INSERT_AT, 32'sh5555_5555, 8'd255);
    send_op(pcl_pkg::OP_INSERT_AT, 32'shAAAA_AAAA, 8'd3);
    send_op(pcl_pkg::OP_SHOW, 32'sd0, 8'd0);
    // deletes in the middle, past the end and at the front
    send_op(pcl_pkg::OP_DEL_AT, 32'sd0, 8'd2);
    send_op(pcl_pkg::OP_DEL_AT, 32'sd0, 8'd255);
    send_op(pcl_pkg::OP_DEL_AT, 32'sd0, 8'd1);
    send_op(pcl_pkg::OP_DEL_AT, 32'sd0, 8'd0);
    send_op(pcl_pkg::OP_DEL_REAR, 32'sd0, 8'd0);
    send_op(pcl_pkg::OP_DEL_FRONT, 32'sd0, 8'd0);
    send_op(OP_UNUSED, 32'sh1234_5678, 8'd7);
    send_op(pcl_pkg::OP_DEL_AT, 32'sd0, 8'd5);
    send_op(pcl_pkg::OP_APPEND, 32'sd1, 8'd0);
    send_op(pcl_pkg::OP_DEL_AT, 32'sd0, 8'd255);
    send_op(pcl_pkg::OP_SHOW, 32'sd0, 8'd0);

    // fill past capacity, then drain
    for (i = 0; i < 40; i++) send(random_cmd(100));
    for (i = 0; i < 30; i++) send(random_cmd(25));

    // long response hold-off while commands keep coming
    hold_req = 1'b1;
    for (i = 0; i < 24; i++) send(random_cmd(60));
    for (i = 0; i < 20; i++) send(random_cmd(70));

    // back to back on both sides
    send_gaps  = 1'b0;
    stall_gaps = 1'b0;
    for (i = 0; i < 24; i++) send(random_cmd(50));

    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("%0d commands sent, %0d response beats checked, %0d mismatches",
             sent, beats, failures);
    $display("list reached %0d of %0d entries; one %0d-cycle response hold-off",
             peak_length, CAPACITY, HOLD_CYCLES);
    if (failures == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
design/pcl_pkg.sv
design/pcl_free_slot.sv
design/positional_circular_list.sv
tb/positional_circular_list_chk.sv
tb/positional_circular_list_tb.sv
